>>> rtl/rbsf_pkg.sv
package rbsf_pkg;

   localparam int MAX_DIM_DEFAULT     = 1024;
   localparam int SAMPLE_BITS_DEFAULT = 24;

   localparam int FRAME_BITS     = 11;
   localparam int RADIUS_BITS    = 18;
   localparam int SIGMA_BITS     = 16;
   localparam int GAIN_BITS      = 16;
   localparam int INDEX_BITS     = 10;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 18;

   localparam int MASK_BITS   = 16;
   localparam int MASK_ONE    = 32768;
   localparam int FACTOR_BITS = 32;
   localparam int FACTOR_FRAC = 27;
   localparam int EXP_BITS    = 32;
   localparam int EXP_STEPS   = 16;
   localparam int GAUSS_LIMIT = 5 * 65536;
   localparam int T_BITS      = 19;
   localparam int U_SHIFT     = 17;
   localparam int RADIUS_FRAC = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH    = 3'd0,
      CSR_FRAME_HEIGHT   = 3'd1,
      CSR_CENTER_RADIUS  = 3'd2,
      CSR_BAND_HALFWIDTH = 3'd3,
      CSR_SIGMA_INVERSE  = 3'd4,
      CSR_GAIN           = 3'd5,
      CSR_INVERT         = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0]  frame_width;
      logic [FRAME_BITS-1:0]  frame_height;
      logic [RADIUS_BITS-1:0] center_radius;
      logic [RADIUS_BITS-1:0] band_halfwidth;
      logic [SIGMA_BITS-1:0]  sigma_inverse;
      logic [GAIN_BITS-1:0]   gain;
      logic                   invert;
   } cfg_type;

   function automatic int root_bits(input int max_dim);
      return (2 * $clog2(max_dim + 1) + 18) / 2;
   endfunction

endpackage

>>> rtl/rbsf_if.sv
interface rbsf_req_if #(parameter int SAMPLE_BITS = rbsf_pkg::SAMPLE_BITS_DEFAULT);
   logic                                valid;
   logic                                ready;
   logic signed [SAMPLE_BITS-1:0]       real_in;
   logic signed [SAMPLE_BITS-1:0]       imag_in;
   logic [rbsf_pkg::INDEX_BITS-1:0]     column;
   logic [rbsf_pkg::INDEX_BITS-1:0]     row;
   modport source (output valid, real_in, imag_in, column, row, input ready);
   modport sink   (input valid, real_in, imag_in, column, row, output ready);
endinterface

interface rbsf_rsp_if #(parameter int SAMPLE_BITS = rbsf_pkg::SAMPLE_BITS_DEFAULT);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] real_out;
   logic signed [SAMPLE_BITS-1:0] imag_out;
   logic                          saturated;
   modport source (output valid, real_out, imag_out, saturated, input ready);
   modport sink   (input valid, real_out, imag_out, saturated, output ready);
endinterface

>>> rtl/radial_band_spectrum_filter.sv
// Radial band filter for a streamed complex spectrum.
//
// req_chan carries one bin a beat: real and imaginary parts with the bin's
// column and row. rsp_chan returns the same bin scaled by a real Gaussian
// band mask (optionally inverted, then multiplied by the gain), rounded and
// saturated, with a flag when either part clipped. Results leave in order.
//
// One beat is taken every cycle while the receiver keeps up; the wrap
// modulo, the square root and the sixteen squarings of the exponential
// each take one pipeline stage per step.
//
// The csr_ port writes one register a cycle, by index; write only while no
// beat is in flight. Reset restores the register defaults and empties the
// pipeline. When the receiver holds off, the whole pipeline holds, the
// output beat stays put and req_chan.ready drops; nothing is lost.
module radial_band_spectrum_filter #(
   parameter int MAX_DIM     = rbsf_pkg::MAX_DIM_DEFAULT,
   parameter int SAMPLE_BITS = rbsf_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   rbsf_req_if.sink                             req_chan,
   rbsf_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [rbsf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rbsf_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   localparam int ROOT_BITS = rbsf_pkg::root_bits(MAX_DIM);
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   rbsf_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            rbsf_pkg::CSR_FRAME_WIDTH:
               cfg_in.frame_width = csr_write_data[rbsf_pkg::FRAME_BITS-1:0];
            rbsf_pkg::CSR_FRAME_HEIGHT:
               cfg_in.frame_height = csr_write_data[rbsf_pkg::FRAME_BITS-1:0];
            rbsf_pkg::CSR_CENTER_RADIUS:
               cfg_in.center_radius = csr_write_data[rbsf_pkg::RADIUS_BITS-1:0];
            rbsf_pkg::CSR_BAND_HALFWIDTH:
               cfg_in.band_halfwidth = csr_write_data[rbsf_pkg::RADIUS_BITS-1:0];
            rbsf_pkg::CSR_SIGMA_INVERSE:
               cfg_in.sigma_inverse = csr_write_data[rbsf_pkg::SIGMA_BITS-1:0];
            rbsf_pkg::CSR_GAIN:
               cfg_in.gain = csr_write_data[rbsf_pkg::GAIN_BITS-1:0];
            rbsf_pkg::CSR_INVERT:
               cfg_in.invert = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width    <= rbsf_pkg::FRAME_BITS'(256);
         cfg_ff.frame_height   <= rbsf_pkg::FRAME_BITS'(256);
         cfg_ff.center_radius  <= rbsf_pkg::RADIUS_BITS'(16384);
         cfg_ff.band_halfwidth <= '0;
         cfg_ff.sigma_inverse  <= rbsf_pkg::SIGMA_BITS'(256);
         cfg_ff.gain           <= rbsf_pkg::GAIN_BITS'(4096);
         cfg_ff.invert         <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   logic advance;
   logic rad_valid, msk_valid;
   logic [ROOT_BITS-1:0] radius;
   logic [rbsf_pkg::FACTOR_BITS-1:0] factor;
   logic [2*SAMPLE_BITS-1:0] samp_a, samp_b;

   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   rbsf_radius #(.MAX_DIM(MAX_DIM), .SAMPLE_BITS(SAMPLE_BITS), .ROOT_BITS(ROOT_BITS)) u_radius (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_chan.valid),
      .column      (req_chan.column),
      .row         (req_chan.row),
      .samples_in  ({req_chan.real_in, req_chan.imag_in}),
      .cfg         (cfg_ff),
      .out_valid   (rad_valid),
      .radius      (radius),
      .samples_out (samp_a)
   );

   rbsf_mask #(.SAMPLE_BITS(SAMPLE_BITS), .ROOT_BITS(ROOT_BITS)) u_mask (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (rad_valid),
      .radius      (radius),
      .samples_in  (samp_a),
      .cfg         (cfg_ff),
      .out_valid   (msk_valid),
      .factor      (factor),
      .samples_out (samp_b)
   );

   rbsf_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (msk_valid),
      .factor     (factor),
      .samples_in (samp_b),
      .out_valid  (rsp_chan.valid),
      .real_out   (rsp_chan.real_out),
      .imag_out   (rsp_chan.imag_out),
      .saturated  (rsp_chan.saturated)
   );

   a_stall_only_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("input held off without output backpressure");

   a_sat_at_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.saturated) |->
         (rsp_chan.real_out == SAMPLE_MAX || rsp_chan.real_out == SAMPLE_MIN ||
          rsp_chan.imag_out == SAMPLE_MAX || rsp_chan.imag_out == SAMPLE_MIN))
      else $error("clip flag without a part at the rail");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("output beat valid straight after reset");

endmodule

>>> rtl/rbsf_radius.sv
module rbsf_radius #(
   parameter int MAX_DIM     = rbsf_pkg::MAX_DIM_DEFAULT,
   parameter int SAMPLE_BITS = rbsf_pkg::SAMPLE_BITS_DEFAULT,
   parameter int ROOT_BITS   = rbsf_pkg::root_bits(MAX_DIM)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic [rbsf_pkg::INDEX_BITS-1:0]   column,
   input  logic [rbsf_pkg::INDEX_BITS-1:0]   row,
   input  logic [2*SAMPLE_BITS-1:0]          samples_in,
   input  rbsf_pkg::cfg_type                 cfg,
   output logic                              out_valid,
   output logic [ROOT_BITS-1:0]              radius,
   output logic [2*SAMPLE_BITS-1:0]          samples_out
);

   localparam int DIM_BITS = $clog2(MAX_DIM + 1);
   localparam int CW       = (DIM_BITS > rbsf_pkg::FRAME_BITS) ? DIM_BITS : rbsf_pkg::FRAME_BITS;
   localparam int SUM_BITS = ((DIM_BITS > rbsf_pkg::INDEX_BITS) ? DIM_BITS
                                                                : rbsf_pkg::INDEX_BITS) + 1;
   localparam int PB       = SUM_BITS + DIM_BITS;
   localparam int D2_BITS  = 2 * DIM_BITS + 1;
   localparam int V_BITS   = 2 * ROOT_BITS;
   localparam int REM_BITS = ROOT_BITS + 3;
   localparam int LAT      = SUM_BITS + 1 + ROOT_BITS;

   function automatic logic [DIM_BITS-1:0] clamp_size(input logic [rbsf_pkg::FRAME_BITS-1:0] s);
      logic [CW-1:0] se;
      se = CW'(s);
      if (s == '0) return DIM_BITS'(1);
      if (se > CW'(MAX_DIM)) return DIM_BITS'(MAX_DIM);
      return DIM_BITS'(se);
   endfunction

   logic [DIM_BITS-1:0] nx, ny, halfx, halfy;
   logic [SUM_BITS-1:0] sum_x, sum_y;

   assign nx    = clamp_size(cfg.frame_width);
   assign ny    = clamp_size(cfg.frame_height);
   assign halfx = nx >> 1;
   assign halfy = ny >> 1;
   assign sum_x = SUM_BITS'(column) + SUM_BITS'(halfx);
   assign sum_y = SUM_BITS'(row) + SUM_BITS'(halfy);

   logic [SUM_BITS-1:0] mx_ff [SUM_BITS];
   logic [SUM_BITS-1:0] my_ff [SUM_BITS];
   logic [SUM_BITS-1:0] mx_in [SUM_BITS];
   logic [SUM_BITS-1:0] my_in [SUM_BITS];

   for (genvar s = 0; s < SUM_BITS; s++) begin : g_mod
      localparam int K = SUM_BITS - 1 - s;
      logic [SUM_BITS-1:0] px, py;
      logic [PB-1:0]       subx, suby;
      if (s == 0) begin : g_first
         assign px = sum_x;
         assign py = sum_y;
      end else begin : g_next
         assign px = mx_ff[s-1];
         assign py = my_ff[s-1];
      end
      always_comb begin
         subx = PB'(nx) << K;
         suby = PB'(ny) << K;
         mx_in[s] = (PB'(px) >= subx) ? SUM_BITS'(PB'(px) - subx) : px;
         my_in[s] = (PB'(py) >= suby) ? SUM_BITS'(PB'(py) - suby) : py;
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            mx_ff[s] <= mx_in[s];
            my_ff[s] <= my_in[s];
         end
      end
   end

   logic [DIM_BITS-1:0] rx, ry, mag_x, mag_y;
   logic [D2_BITS-1:0]  d2_in, d2_ff;

   always_comb begin
      rx    = DIM_BITS'(mx_ff[SUM_BITS-1]);
      ry    = DIM_BITS'(my_ff[SUM_BITS-1]);
      mag_x = (rx >= halfx) ? rx - halfx : halfx - rx;
      mag_y = (ry >= halfy) ? ry - halfy : halfy - ry;
      d2_in = D2_BITS'(mag_x) * D2_BITS'(mag_x) + D2_BITS'(mag_y) * D2_BITS'(mag_y);
   end

   always_ff @(posedge clock) begin
      if (advance) d2_ff <= d2_in;
   end

   logic [REM_BITS-1:0]  sr_rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] sr_root_ff [ROOT_BITS];
   logic [V_BITS-1:0]    sr_v_ff    [ROOT_BITS];
   logic [REM_BITS-1:0]  sr_rem_in  [ROOT_BITS];
   logic [ROOT_BITS-1:0] sr_root_in [ROOT_BITS];

   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sqrt
      logic [REM_BITS-1:0]  prem, cur, trial;
      logic [ROOT_BITS-1:0] proot;
      logic [V_BITS-1:0]    pv;
      if (j == 0) begin : g_first
         assign prem  = '0;
         assign proot = '0;
         assign pv    = V_BITS'(d2_ff) << rbsf_pkg::RADIUS_FRAC;
      end else begin : g_next
         assign prem  = sr_rem_ff[j-1];
         assign proot = sr_root_ff[j-1];
         assign pv    = sr_v_ff[j-1];
      end
      always_comb begin
         cur   = {prem[REM_BITS-3:0], pv[V_BITS-1-2*j -: 2]};
         trial = REM_BITS'({proot, 2'b01});
         if (cur >= trial) begin
            sr_rem_in[j]  = cur - trial;
            sr_root_in[j] = {proot[ROOT_BITS-2:0], 1'b1};
         end else begin
            sr_rem_in[j]  = cur;
            sr_root_in[j] = {proot[ROOT_BITS-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            sr_rem_ff[j]  <= sr_rem_in[j];
            sr_root_ff[j] <= sr_root_in[j];
            sr_v_ff[j]    <= pv;
         end
      end
   end

   logic                     valid_ff [LAT];
   logic [2*SAMPLE_BITS-1:0] samp_ff  [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < LAT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         samp_ff[0] <= samples_in;
         for (int i = 1; i < LAT; i++) samp_ff[i] <= samp_ff[i-1];
      end
   end

   assign out_valid   = valid_ff[LAT-1];
   assign radius      = sr_root_ff[ROOT_BITS-1];
   assign samples_out = samp_ff[LAT-1];

endmodule

>>> rtl/rbsf_mask.sv
module rbsf_mask #(
   parameter int SAMPLE_BITS = rbsf_pkg::SAMPLE_BITS_DEFAULT,
   parameter int ROOT_BITS   = rbsf_pkg::root_bits(rbsf_pkg::MAX_DIM_DEFAULT)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic [ROOT_BITS-1:0]                radius,
   input  logic [2*SAMPLE_BITS-1:0]            samples_in,
   input  rbsf_pkg::cfg_type                   cfg,
   output logic                                out_valid,
   output logic [rbsf_pkg::FACTOR_BITS-1:0]    factor,
   output logic [2*SAMPLE_BITS-1:0]            samples_out
);

   localparam int XB   = (ROOT_BITS > rbsf_pkg::RADIUS_BITS) ? ROOT_BITS : rbsf_pkg::RADIUS_BITS;
   localparam int TB   = XB + rbsf_pkg::SIGMA_BITS;
   localparam int TSQ  = 2 * rbsf_pkg::T_BITS;
   localparam int UB   = TSQ - rbsf_pkg::U_SHIFT;
   localparam int EB   = rbsf_pkg::EXP_BITS;
   localparam int NS   = rbsf_pkg::EXP_STEPS;
   localparam int MB   = rbsf_pkg::MASK_BITS;
   localparam int LAT  = NS + 5;

   logic [XB-1:0] d_ext, c_ext, hw_ext, diff, x_in, x_ff;

   always_comb begin
      d_ext  = XB'(radius);
      c_ext  = XB'(cfg.center_radius);
      hw_ext = XB'(cfg.band_halfwidth);
      diff   = (d_ext >= c_ext) ? d_ext - c_ext : c_ext - d_ext;
      x_in   = (diff > hw_ext) ? diff - hw_ext : '0;
   end

   logic [TB-1:0] t_in, t_ff;
   logic          big_t_ff;

   assign t_in = TB'(x_ff) * TB'(cfg.sigma_inverse);

   logic [rbsf_pkg::T_BITS-1:0] t_low;
   logic [TSQ-1:0]              tsq;
   logic [UB-1:0]               u_in, u_ff;
   logic                        big_u_ff;

   always_comb begin
      t_low = t_ff[rbsf_pkg::T_BITS-1:0];
      tsq   = TSQ'(t_low) * TSQ'(t_low);
      u_in  = tsq[TSQ-1:rbsf_pkg::U_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff     <= x_in;
         t_ff     <= t_in;
         big_t_ff <= (t_in >= TB'(rbsf_pkg::GAUSS_LIMIT));
         u_ff     <= u_in;
         big_u_ff <= big_t_ff;
      end
   end

   logic [EB-1:0] b_ff    [NS];
   logic          big_ff  [NS];
   logic          zero_ff [NS];
   logic [EB-1:0] b_in    [NS];

   for (genvar i = 0; i < NS; i++) begin : g_exp
      logic [EB-1:0]   pb;
      logic            pbig, pzero;
      logic [2*EB-1:0] sq;
      if (i == 0) begin : g_first
         assign pb    = EB'((EB+1)'(1) << EB) - EB'(u_ff);
         assign pbig  = big_u_ff;
         assign pzero = (u_ff == '0);
      end else begin : g_next
         assign pb    = b_ff[i-1];
         assign pbig  = big_ff[i-1];
         assign pzero = zero_ff[i-1];
      end
      always_comb begin
         sq      = (2*EB)'(pb) * (2*EB)'(pb) + ((2*EB)'(1) << (EB - 1));
         b_in[i] = sq[2*EB-1:EB];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            b_ff[i]    <= b_in[i];
            big_ff[i]  <= pbig;
            zero_ff[i] <= pzero;
         end
      end
   end

   logic [EB:0]    b_round;
   logic [MB-1:0]  gauss, mask_in, mask_ff;
   logic [rbsf_pkg::FACTOR_BITS-1:0] factor_ff;

   always_comb begin
      b_round = (EB+1)'(b_ff[NS-1]) + ((EB+1)'(1) << (MB));
      priority if (big_ff[NS-1]) gauss = '0;
      else if (zero_ff[NS-1])    gauss = MB'(rbsf_pkg::MASK_ONE);
      else                       gauss = MB'(b_round >> (MB + 1));
      mask_in = cfg.invert ? MB'(rbsf_pkg::MASK_ONE) - gauss : gauss;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mask_ff   <= mask_in;
         factor_ff <= rbsf_pkg::FACTOR_BITS'(mask_ff) * rbsf_pkg::FACTOR_BITS'(cfg.gain);
      end
   end

   logic                     valid_ff [LAT];
   logic [2*SAMPLE_BITS-1:0] samp_ff  [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < LAT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         samp_ff[0] <= samples_in;
         for (int i = 1; i < LAT; i++) samp_ff[i] <= samp_ff[i-1];
      end
   end

   assign out_valid   = valid_ff[LAT-1];
   assign factor      = factor_ff;
   assign samples_out = samp_ff[LAT-1];

endmodule

>>> rtl/rbsf_scale.sv
module rbsf_scale #(
   parameter int SAMPLE_BITS = rbsf_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic [rbsf_pkg::FACTOR_BITS-1:0]  factor,
   input  logic [2*SAMPLE_BITS-1:0]          samples_in,
   output logic                              out_valid,
   output logic signed [SAMPLE_BITS-1:0]     real_out,
   output logic signed [SAMPLE_BITS-1:0]     imag_out,
   output logic                              saturated
);

   localparam int SB = SAMPLE_BITS;
   localparam int PB = SB + rbsf_pkg::FACTOR_BITS;
   localparam int RB = PB + 1;
   localparam int QB = RB - rbsf_pkg::FACTOR_FRAC;

   function automatic logic [SB-1:0] magnitude(input logic [SB-1:0] raw);
      return raw[SB-1] ? (~raw + 1'b1) : raw;
   endfunction

   function automatic logic [SB:0] round_sat(input logic [PB-1:0] prod, input logic neg);
      logic [RB-1:0] r;
      logic [QB-1:0] p, np;
      logic [QB-1:0] lim;
      r   = RB'(prod) + (RB'(1) << (rbsf_pkg::FACTOR_FRAC - 1));
      p   = r[RB-1:rbsf_pkg::FACTOR_FRAC];
      np  = ~p + 1'b1;
      lim = QB'(64'd1 << (SB - 1));
      if (neg) begin
         if (p > lim) return {1'b1, 1'b1, {(SB-1){1'b0}}};
         return {1'b0, np[SB-1:0]};
      end
      if (p > lim - 1'b1) return {1'b1, 1'b0, {(SB-1){1'b1}}};
      return {1'b0, p[SB-1:0]};
   endfunction

   logic [SB-1:0] raw_r, raw_i;
   logic [PB-1:0] prod_r_ff, prod_i_ff;
   logic          neg_r_ff, neg_i_ff, valid_p_ff;

   assign raw_r = samples_in[2*SB-1:SB];
   assign raw_i = samples_in[SB-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_r_ff <= PB'(magnitude(raw_r)) * PB'(factor);
         prod_i_ff <= PB'(magnitude(raw_i)) * PB'(factor);
         neg_r_ff  <= raw_r[SB-1];
         neg_i_ff  <= raw_i[SB-1];
      end
   end

   logic [SB:0] res_r, res_i;
   logic [SB-1:0] real_out_ff, imag_out_ff;
   logic          sat_ff, valid_o_ff;

   assign res_r = round_sat(prod_r_ff, neg_r_ff);
   assign res_i = round_sat(prod_i_ff, neg_i_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         real_out_ff <= res_r[SB-1:0];
         imag_out_ff <= res_i[SB-1:0];
         sat_ff      <= res_r[SB] | res_i[SB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_p_ff <= 1'b0;
         valid_o_ff <= 1'b0;
      end else if (advance) begin
         valid_p_ff <= in_valid;
         valid_o_ff <= valid_p_ff;
      end
   end

   assign out_valid = valid_o_ff;
   assign real_out  = signed'(real_out_ff);
   assign imag_out  = signed'(imag_out_ff);
   assign saturated = sat_ff;

endmodule
